@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is held.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Same check with a fixed message for bounds.
`define ASSERT_BOUND(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("value out of bounds");

`endif

@@ sv/plob_pkg.sv @@
// ----------------------------------------------------------------------------
// plob_pkg
// Shared constants and types of the price-level order book.
// ----------------------------------------------------------------------------
`default_nettype none

package plob_pkg;

  localparam int MaxLevels = 64;
  localparam int MaxView   = 16;
  localparam int LvlIdxW   = $clog2(MaxLevels);
  localparam int CntW      = $clog2(MaxLevels + 1);
  localparam int EntryW    = 64;

  localparam logic [4:0] DepthReset = 5'd10;

  localparam logic [1:0] ActAdd    = 2'd0;
  localparam logic [1:0] ActReduce = 2'd1;
  localparam logic [1:0] ActIgnore = 2'd2;
  localparam logic [1:0] ActClear  = 2'd3;

  localparam logic [1:0] SideBid = 2'd0;
  localparam logic [1:0] SideAsk = 2'd1;

  typedef enum logic [3:0] {
    OpNone,
    OpCapture,
    OpRead,
    OpNext,
    OpWrUpd,
    OpSetOvf,
    OpInsInit,
    OpShRdDn,
    OpShWrDn,
    OpWrNew,
    OpShRdUp,
    OpShWrUp,
    OpDec,
    OpPubInit,
    OpPubRead,
    OpPubEmit
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic book_item;
    logic is_add;
    logic publish;
    logic cnt_end;
    logic match;
    logic beyond;
    logic full;
    logic remove;
    logic at_pos;
    logic up_end;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/price_level_order_book.sv @@
// ----------------------------------------------------------------------------
// price_level_order_book
// Price-level book with sorted bid and ask tables and top-of-book rows.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; busy_o then stays
// high until the item is applied and its rows are out. The tables live in
// one RAM per side and are searched one entry at a time, with a read state
// and a compare state per entry, so an add or a partial reduce of a level
// found at position k reads k + 1 entries before it writes the level back.
// An insert or a removal adds a read and a write state per entry moved and a
// final write or count step; a publish adds a read and an emit state per row.
// Each row is shown for one cycle on row_valid_o and cannot be held off.
// view_depth may be written only while busy_o is low.
`default_nettype none

module price_level_order_book (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [1:0]  side_i,
  input  wire logic [31:0] price_i,
  input  wire logic [31:0] quantity_i,
  input  wire logic        publish_i,
  input  wire logic        view_depth_we_i,
  input  wire logic [4:0]  view_depth_i,
  output logic             row_valid_o,
  output logic [3:0]       row_index_o,
  output logic             bid_valid_o,
  output logic [31:0]      bid_price_o,
  output logic [31:0]      bid_quantity_o,
  output logic             ask_valid_o,
  output logic [31:0]      ask_price_o,
  output logic [31:0]      ask_quantity_o,
  output logic             overflow_o,
  output logic             last_row_o
);

  plob_pkg::dp_cmd_t  cmd;
  plob_pkg::dp_stat_t stat;
  logic [4:0]         depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= plob_pkg::DepthReset;
    end else if (view_depth_we_i) begin
      depth_q <= view_depth_i;
    end
  end

  plob_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  plob_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .side_i        (side_i),
    .price_i       (price_i),
    .quantity_i    (quantity_i),
    .publish_i     (publish_i),
    .view_depth_i  (depth_q),
    .row_valid_o   (row_valid_o),
    .row_index_o   (row_index_o),
    .bid_valid_o   (bid_valid_o),
    .bid_price_o   (bid_price_o),
    .bid_quantity_o(bid_quantity_o),
    .ask_valid_o   (ask_valid_o),
    .ask_price_o   (ask_price_o),
    .ask_quantity_o(ask_quantity_o),
    .overflow_o    (overflow_o),
    .last_row_o    (last_row_o)
  );

endmodule

`default_nettype wire

@@ sv/plob_ram.sv @@
// ----------------------------------------------------------------------------
// plob_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/plob_datapath.sv @@
// ----------------------------------------------------------------------------
// plob_datapath
// Level tables, counts, item registers and the publish output registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module plob_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire plob_pkg::dp_cmd_t   cmd_i,
  output plob_pkg::dp_stat_t       stat_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [1:0]          side_i,
  input  wire logic [31:0]         price_i,
  input  wire logic [31:0]         quantity_i,
  input  wire logic                publish_i,
  input  wire logic [4:0]          view_depth_i,
  output logic                     row_valid_o,
  output logic [3:0]               row_index_o,
  output logic                     bid_valid_o,
  output logic [31:0]              bid_price_o,
  output logic [31:0]              bid_quantity_o,
  output logic                     ask_valid_o,
  output logic [31:0]              ask_price_o,
  output logic [31:0]              ask_quantity_o,
  output logic                     overflow_o,
  output logic                     last_row_o
);

  localparam int CntW = plob_pkg::CntW;
  localparam int AW   = plob_pkg::LvlIdxW;
  localparam int EW   = plob_pkg::EntryW;

  logic [1:0]      action_q, side_q;
  logic [31:0]     price_q, qty_q;
  logic            publish_q;
  logic [CntW-1:0] bid_cnt_q, bid_cnt_d, ask_cnt_q, ask_cnt_d;
  logic [CntW-1:0] idx_q, idx_d, pos_q, pos_d;
  logic            ovf_q, ovf_d;
  logic            strobe_q;

  logic            is_ask;
  logic [CntW-1:0] act_cnt;
  logic [EW-1:0]   bid_rd, ask_rd, act_rd;
  logic [31:0]     rd_price, rd_qty;
  logic [32:0]     sum;
  logic [31:0]     upd_qty;
  logic            we, re_act, re_pub;
  logic [CntW-1:0] raddr_full;
  logic [EW-1:0]   wdata;
  logic [4:0]      rows;
  logic [CntW-1:0] idx_inc, idx_dec;

  assign is_ask   = side_q[0];
  assign act_cnt  = is_ask ? ask_cnt_q : bid_cnt_q;
  assign act_rd   = is_ask ? ask_rd : bid_rd;
  assign rd_price = act_rd[63:32];
  assign rd_qty   = act_rd[31:0];
  assign idx_inc  = idx_q + CntW'(1);
  assign idx_dec  = idx_q - CntW'(1);
  assign sum      = {1'b0, rd_qty} + {1'b0, qty_q};

  always_comb begin
    if (action_q == plob_pkg::ActAdd) begin
      upd_qty = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end else begin
      upd_qty = rd_qty - qty_q;
    end
  end

  always_comb begin
    if (view_depth_i == 5'd0) begin
      rows = 5'd1;
    end else if (view_depth_i > 5'(plob_pkg::MaxView)) begin
      rows = 5'(plob_pkg::MaxView);
    end else begin
      rows = view_depth_i;
    end
  end

  // Memory port steering per datapath command.
  always_comb begin
    we         = 1'b0;
    re_act     = 1'b0;
    re_pub     = 1'b0;
    raddr_full = idx_q;
    wdata      = act_rd;
    case (cmd_i.op) inside
      plob_pkg::OpRead:   re_act = 1'b1;
      plob_pkg::OpShRdDn: begin
        re_act     = 1'b1;
        raddr_full = idx_dec;
      end
      plob_pkg::OpShRdUp: begin
        re_act     = 1'b1;
        raddr_full = idx_inc;
      end
      plob_pkg::OpShWrDn, plob_pkg::OpShWrUp: we = 1'b1;
      plob_pkg::OpWrUpd: begin
        we    = 1'b1;
        wdata = {price_q, upd_qty};
      end
      plob_pkg::OpWrNew: begin
        we    = 1'b1;
        wdata = {price_q, qty_q};
      end
      plob_pkg::OpPubRead: re_pub = 1'b1;
      default: ;
    endcase
  end

  plob_ram #(.Width(EW), .Depth(plob_pkg::MaxLevels)) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (we && !is_ask),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re_pub || (re_act && !is_ask)),
    .raddr_i (raddr_full[AW-1:0]),
    .rdata_o (bid_rd)
  );

  plob_ram #(.Width(EW), .Depth(plob_pkg::MaxLevels)) u_ask_ram (
    .clk_i   (clk_i),
    .we_i    (we && is_ask),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re_pub || (re_act && is_ask)),
    .raddr_i (raddr_full[AW-1:0]),
    .rdata_o (ask_rd)
  );

  always_comb begin
    bid_cnt_d = bid_cnt_q;
    ask_cnt_d = ask_cnt_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    ovf_d     = ovf_q;
    case (cmd_i.op) inside
      plob_pkg::OpCapture: begin
        idx_d = '0;
        if (action_i == plob_pkg::ActClear) begin
          bid_cnt_d = '0;
          ask_cnt_d = '0;
          ovf_d     = 1'b0;
        end
      end
      plob_pkg::OpNext, plob_pkg::OpShWrUp, plob_pkg::OpPubEmit: idx_d = idx_inc;
      plob_pkg::OpShWrDn: idx_d = idx_dec;
      plob_pkg::OpSetOvf: ovf_d = 1'b1;
      plob_pkg::OpInsInit: begin
        pos_d = idx_q;
        idx_d = act_cnt;
      end
      plob_pkg::OpWrNew: begin
        if (is_ask) begin
          ask_cnt_d = ask_cnt_q + CntW'(1);
        end else begin
          bid_cnt_d = bid_cnt_q + CntW'(1);
        end
      end
      plob_pkg::OpDec: begin
        if (is_ask) begin
          ask_cnt_d = ask_cnt_q - CntW'(1);
        end else begin
          bid_cnt_d = bid_cnt_q - CntW'(1);
        end
      end
      plob_pkg::OpPubInit: idx_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_cnt_q <= '0;
      ask_cnt_q <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      bid_cnt_q <= bid_cnt_d;
      ask_cnt_q <= ask_cnt_d;
      idx_q     <= idx_d;
      pos_q     <= pos_d;
      ovf_q     <= ovf_d;
      strobe_q  <= (cmd_i.op == plob_pkg::OpPubEmit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == plob_pkg::OpCapture) begin
      action_q  <= action_i;
      side_q    <= side_i;
      price_q   <= price_i;
      qty_q     <= quantity_i;
      publish_q <= publish_i;
    end
    if (cmd_i.op == plob_pkg::OpPubEmit) begin
      row_index_o    <= idx_q[3:0];
      bid_valid_o    <= idx_q < bid_cnt_q;
      bid_price_o    <= (idx_q < bid_cnt_q) ? bid_rd[63:32] : 32'd0;
      bid_quantity_o <= (idx_q < bid_cnt_q) ? bid_rd[31:0] : 32'd0;
      ask_valid_o    <= idx_q < ask_cnt_q;
      ask_price_o    <= (idx_q < ask_cnt_q) ? ask_rd[63:32] : 32'd0;
      ask_quantity_o <= (idx_q < ask_cnt_q) ? ask_rd[31:0] : 32'd0;
      overflow_o     <= ovf_q;
      last_row_o     <= stat_o.last;
    end
  end

  assign row_valid_o = strobe_q;

  assign stat_o.book_item = (action_q == plob_pkg::ActAdd || action_q == plob_pkg::ActReduce)
                            && (side_q == plob_pkg::SideBid || side_q == plob_pkg::SideAsk);
  assign stat_o.is_add    = action_q == plob_pkg::ActAdd;
  assign stat_o.publish   = publish_q;
  assign stat_o.cnt_end   = idx_q == act_cnt;
  assign stat_o.match     = rd_price == price_q;
  assign stat_o.beyond    = is_ask ? (rd_price > price_q) : (rd_price < price_q);
  assign stat_o.full      = act_cnt == CntW'(plob_pkg::MaxLevels);
  assign stat_o.remove    = qty_q >= rd_qty;
  assign stat_o.at_pos    = idx_q == pos_q;
  assign stat_o.up_end    = idx_inc == act_cnt;
  assign stat_o.last      = idx_inc == CntW'(rows);

  `ASSERT_BOUND(a_bid_cnt, clk_i, rst_ni, bid_cnt_q <= CntW'(plob_pkg::MaxLevels))
  `ASSERT_BOUND(a_ask_cnt, clk_i, rst_ni, ask_cnt_q <= CntW'(plob_pkg::MaxLevels))
  `ASSERT_AT(a_row_gap, clk_i, rst_ni, strobe_q |=> !strobe_q)

endmodule

`default_nettype wire

@@ sv/plob_ctrl.sv @@
// ----------------------------------------------------------------------------
// plob_ctrl
// Sequencer for search, shift, update and publish of the order book.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire plob_pkg::dp_stat_t stat_i,
  output plob_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [12:0] {
    StIdle  = 13'b0000000000001,
    StDisp  = 13'b0000000000010,
    StSrch  = 13'b0000000000100,
    StCmp   = 13'b0000000001000,
    StNotFd = 13'b0000000010000,
    StIns   = 13'b0000000100000,
    StInsW  = 13'b0000001000000,
    StRm    = 13'b0000010000000,
    StRmW   = 13'b0000100000000,
    StPubI  = 13'b0001000000000,
    StPRd   = 13'b0010000000000,
    StPEmit = 13'b0100000000000,
    StFound = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = plob_pkg::OpNone;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.op = plob_pkg::OpCapture;
          state_d  = StDisp;
        end
      end
      StDisp:  state_d = stat_i.book_item ? StSrch : StPubI;
      StSrch: begin
        if (stat_i.cnt_end) begin
          state_d = StNotFd;
        end else begin
          cmd_o.op = plob_pkg::OpRead;
          state_d  = StCmp;
        end
      end
      StCmp: begin
        if (stat_i.match) begin
          state_d = StFound;
        end else if (stat_i.beyond) begin
          state_d = StNotFd;
        end else begin
          cmd_o.op = plob_pkg::OpNext;
          state_d  = StSrch;
        end
      end
      StFound: begin
        if (!stat_i.is_add && stat_i.remove) begin
          state_d = StRm;
        end else begin
          cmd_o.op = plob_pkg::OpWrUpd;
          state_d  = StPubI;
        end
      end
      StNotFd: begin
        if (!stat_i.is_add) begin
          state_d = StPubI;
        end else if (stat_i.full) begin
          cmd_o.op = plob_pkg::OpSetOvf;
          state_d  = StPubI;
        end else begin
          cmd_o.op = plob_pkg::OpInsInit;
          state_d  = StIns;
        end
      end
      // Insert opens a gap by moving entries up from the tail.
      StIns: begin
        if (stat_i.at_pos) begin
          cmd_o.op = plob_pkg::OpWrNew;
          state_d  = StPubI;
        end else begin
          cmd_o.op = plob_pkg::OpShRdDn;
          state_d  = StInsW;
        end
      end
      StInsW: begin
        cmd_o.op = plob_pkg::OpShWrDn;
        state_d  = StIns;
      end
      // Remove closes the gap by moving later entries down.
      StRm: begin
        if (stat_i.up_end) begin
          cmd_o.op = plob_pkg::OpDec;
          state_d  = StPubI;
        end else begin
          cmd_o.op = plob_pkg::OpShRdUp;
          state_d  = StRmW;
        end
      end
      StRmW: begin
        cmd_o.op = plob_pkg::OpShWrUp;
        state_d  = StRm;
      end
      StPubI: begin
        cmd_o.op = plob_pkg::OpPubInit;
        state_d  = stat_i.publish ? StPRd : StIdle;
      end
      StPRd: begin
        cmd_o.op = plob_pkg::OpPubRead;
        state_d  = StPEmit;
      end
      StPEmit: begin
        cmd_o.op = plob_pkg::OpPubEmit;
        state_d  = stat_i.last ? StIdle : StPRd;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != StIdle;

endmodule

`default_nettype wire

@@ tb/sv/tb_price_level_order_book.sv @@
// ----------------------------------------------------------------------------
// tb_price_level_order_book
// Self-checking testbench for the price-level order book.
// ----------------------------------------------------------------------------
// Each accepted word is applied to a behavioral copy of both sorted tables.
// When publish is set, the top-of-book rows it should produce are queued.
// A monitor compares every strobed row with the oldest queued row. Named
// tests cover the register, the add and reduce corner cases, a full side,
// and a long run of random book traffic with random gaps on the sender.
`default_nettype none

module tb_price_level_order_book;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] SideOdd  = 2'd2;
  localparam logic [1:0] SideOdd3 = 2'd3;
  localparam int         IdleLimit = 20000;

  typedef struct packed {
    logic [3:0]  row_index;
    logic        bid_valid;
    logic [31:0] bid_price;
    logic [31:0] bid_quantity;
    logic        ask_valid;
    logic [31:0] ask_price;
    logic [31:0] ask_quantity;
    logic        overflow;
    logic        last_row;
  } book_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  action_i = '0;
  logic [1:0]  side_i = '0;
  logic [31:0] price_i = '0;
  logic [31:0] quantity_i = '0;
  logic        publish_i = 1'b0;
  logic        view_depth_we_i = 1'b0;
  logic [4:0]  view_depth_i = '0;
  logic        row_valid_o;
  logic [3:0]  row_index_o;
  logic        bid_valid_o;
  logic [31:0] bid_price_o;
  logic [31:0] bid_quantity_o;
  logic        ask_valid_o;
  logic [31:0] ask_price_o;
  logic [31:0] ask_quantity_o;
  logic        overflow_o;
  logic        last_row_o;

  // Book shadow: index 0 is the bid side, index 1 the ask side.
  logic [31:0] lvl_px  [2][plob_pkg::MaxLevels];
  logic [31:0] lvl_qty [2][plob_pkg::MaxLevels];
  int          lvl_cnt [2];
  logic        ovf_seen;
  logic [4:0]  depth_reg;

  book_row_t   rows_due_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  price_level_order_book u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .side_i, .price_i,
    .quantity_i, .publish_i, .view_depth_we_i, .view_depth_i, .row_valid_o,
    .row_index_o, .bid_valid_o, .bid_price_o, .bid_quantity_o, .ask_valid_o,
    .ask_price_o, .ask_quantity_o, .overflow_o, .last_row_o
  );

  task automatic apply_level(int s, logic [1:0] act, logic [31:0] px,
                             logic [31:0] qty);
    int         i;
    int         n;
    bit         found;
    logic [32:0] sum;
    n = lvl_cnt[s];
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (lvl_px[s][i] == px) begin
        found = 1'b1;
        break;
      end
      if ((s == 0) ? (lvl_px[s][i] < px) : (lvl_px[s][i] > px)) break;
    end
    if (act == plob_pkg::ActAdd) begin
      if (found) begin
        sum = {1'b0, lvl_qty[s][i]} + {1'b0, qty};
        lvl_qty[s][i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else if (n >= plob_pkg::MaxLevels) begin
        ovf_seen = 1'b1;
      end else begin
        for (int j = n; j > i; j--) begin
          lvl_px[s][j]  = lvl_px[s][j-1];
          lvl_qty[s][j] = lvl_qty[s][j-1];
        end
        lvl_px[s][i]  = px;
        lvl_qty[s][i] = qty;
        lvl_cnt[s]    = n + 1;
      end
    end else if (act == plob_pkg::ActReduce && found) begin
      if (qty >= lvl_qty[s][i]) begin
        for (int j = i; j < n - 1; j++) begin
          lvl_px[s][j]  = lvl_px[s][j+1];
          lvl_qty[s][j] = lvl_qty[s][j+1];
        end
        lvl_cnt[s] = n - 1;
      end else begin
        lvl_qty[s][i] = lvl_qty[s][i] - qty;
      end
    end
  endtask

  task automatic predict_rows(logic [1:0] act, logic [1:0] sd, logic [31:0] px,
                              logic [31:0] qty, logic pub);
    int        nrows;
    book_row_t r;
    if (act == plob_pkg::ActClear) begin
      lvl_cnt[0] = 0;
      lvl_cnt[1] = 0;
      ovf_seen   = 1'b0;
    end else if (act == plob_pkg::ActAdd || act == plob_pkg::ActReduce) begin
      if (sd == plob_pkg::SideBid) apply_level(0, act, px, qty);
      else if (sd == plob_pkg::SideAsk) apply_level(1, act, px, qty);
    end
    if (!pub) return;
    nrows = depth_reg;
    if (nrows < 1) nrows = 1;
    if (nrows > plob_pkg::MaxView) nrows = plob_pkg::MaxView;
    for (int k = 0; k < nrows; k++) begin
      r = '0;
      r.row_index = k[3:0];
      if (k < lvl_cnt[0]) begin
        r.bid_valid    = 1'b1;
        r.bid_price    = lvl_px[0][k];
        r.bid_quantity = lvl_qty[0][k];
      end
      if (k < lvl_cnt[1]) begin
        r.ask_valid    = 1'b1;
        r.ask_price    = lvl_px[1][k];
        r.ask_quantity = lvl_qty[1][k];
      end
      r.overflow = ovf_seen;
      r.last_row = (k == nrows - 1);
      rows_due_q.push_back(r);
    end
  endtask

  // Leaves start_i high so that a following word can go back to back.
  task automatic send_word(logic [1:0] act, logic [1:0] sd, logic [31:0] px,
                           logic [31:0] qty, logic pub);
    start_i    <= 1'b1;
    action_i   <= act;
    side_i     <= sd;
    price_i    <= px;
    quantity_i <= qty;
    publish_i  <= pub;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    predict_rows(act, sd, px, qty, pub);
  endtask

  task automatic sender_gap();
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) n = 0;
    else if (pick < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n == 0) return;
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits until every queued row has been seen and the block has gone idle.
  task automatic drain_book();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (rows_due_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_depth(logic [4:0] d);
    drain_book();
    view_depth_we_i <= 1'b1;
    view_depth_i    <= d;
    @(posedge clk_i);
    depth_reg = d;
    view_depth_we_i <= 1'b0;
  endtask

  task automatic test_depth_register();
    logic [4:0] depths[6];
    depths = '{5'd10, 5'd0, 5'd1, 5'd16, 5'd31, 5'd17};
    send_word(plob_pkg::ActAdd, plob_pkg::SideBid, 32'd100, 32'd5, 1'b1);
    send_word(plob_pkg::ActAdd, plob_pkg::SideAsk, 32'd101, 32'd7, 1'b1);
    foreach (depths[k]) begin
      set_depth(depths[k]);
      send_word(plob_pkg::ActIgnore, plob_pkg::SideBid, 32'd0, 32'd0, 1'b1);
    end
    set_depth(5'd4);
  endtask

  task automatic test_corner_cases();
    send_word(plob_pkg::ActClear, SideOdd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // Zero-quantity insert, then saturation at the top of the range.
    send_word(plob_pkg::ActAdd, plob_pkg::SideBid, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_word(plob_pkg::ActAdd, plob_pkg::SideBid, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
    send_word(plob_pkg::ActAdd, plob_pkg::SideBid, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(plob_pkg::ActAdd, plob_pkg::SideBid, 32'd0, 32'd1, 1'b1);
    send_word(plob_pkg::ActAdd, plob_pkg::SideAsk, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_word(plob_pkg::ActAdd, plob_pkg::SideAsk, 32'hFFFF_FFFF, 32'd3, 1'b0);
    send_word(plob_pkg::ActAdd, plob_pkg::SideAsk, 32'h8000_0000, 32'd9, 1'b1);
    // Partial reduce, exact reduce, over-reduce, reduce of an absent level.
    send_word(plob_pkg::ActReduce, plob_pkg::SideAsk, 32'h8000_0000, 32'd4, 1'b1);
    send_word(plob_pkg::ActReduce, plob_pkg::SideAsk, 32'h8000_0000, 32'd5, 1'b1);
    send_word(plob_pkg::ActReduce, plob_pkg::SideBid, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_word(plob_pkg::ActReduce, plob_pkg::SideBid, 32'd12345, 32'd1, 1'b1);
    // Unknown sides and the ignored action leave the book alone.
    send_word(plob_pkg::ActAdd, SideOdd, 32'd55, 32'd1, 1'b1);
    send_word(plob_pkg::ActReduce, SideOdd3, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_word(plob_pkg::ActIgnore, plob_pkg::SideAsk, 32'd0, 32'd1, 1'b1);
    sender_gap();
  endtask

  task automatic test_full_side();
    send_word(plob_pkg::ActClear, plob_pkg::SideBid, 32'd0, 32'd0, 1'b0);
    set_depth(5'd16);
    for (int k = 0; k < plob_pkg::MaxLevels; k++) begin
      send_word(plob_pkg::ActAdd, plob_pkg::SideBid, 32'h0100_0000 + k * 32'd3,
                32'(k + 1), 1'b0);
      send_word(plob_pkg::ActAdd, plob_pkg::SideAsk, 32'hF000_0000 - k * 32'd7,
                32'(k + 2), 1'b0);
    end
    send_word(plob_pkg::ActAdd, plob_pkg::SideBid, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_word(plob_pkg::ActAdd, plob_pkg::SideAsk, 32'd0, 32'd1, 1'b1);
    // The flag stays set after a level is freed; only a clear drops it.
    send_word(plob_pkg::ActReduce, plob_pkg::SideBid, 32'h0100_0000, 32'd99, 1'b1);
    send_word(plob_pkg::ActAdd, plob_pkg::SideBid, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_word(plob_pkg::ActClear, plob_pkg::SideAsk, 32'd0, 32'd0, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [31:0] base;
    logic [1:0]  act;
    logic [1:0]  sd;
    logic [31:0] px;
    logic [31:0] qty;
    int          pick;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 3) drain_book();
      set_depth(phase == 5 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16)));
      base = $urandom();
      for (int n = 0; n < 17; n++) begin
        pick = $urandom_range(0, 99);
        act  = (pick < 55) ? plob_pkg::ActAdd : (pick < 90) ? plob_pkg::ActReduce :
               (pick < 96) ? plob_pkg::ActIgnore : plob_pkg::ActClear;
        sd   = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3)) :
               2'($urandom_range(0, 1));
        px   = ($urandom_range(0, 9) == 0) ? $urandom() :
               base + $urandom_range(0, 24);
        qty  = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 40);
        send_word(act, sd, px, qty, $urandom_range(0, 2) == 0);
        sender_gap();
      end
    end
  endtask

  always @(posedge clk_i) begin
    book_row_t got;
    book_row_t want;
    if (rst_ni && row_valid_o) begin
      got = '{row_index_o, bid_valid_o, bid_price_o, bid_quantity_o, ask_valid_o,
              ask_price_o, ask_quantity_o, overflow_o, last_row_o};
      if (rows_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row: %p", got);
      end else begin
        want = rows_due_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("row mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || row_valid_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_price_level_order_book failed");
      $finish;
    end
  end

  initial begin
    lvl_cnt[0] = 0;
    lvl_cnt[1] = 0;
    ovf_seen   = 1'b0;
    depth_reg  = plob_pkg::DepthReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_depth_register();
    test_corner_cases();
    test_full_side();
    test_random_traffic();
    drain_book();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && rows_due_q.size() == 0) begin
      $display("tb_price_level_order_book passed");
    end else begin
      $display("tb_price_level_order_book failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/plob_pkg.sv
sv/plob_ram.sv
sv/plob_datapath.sv
sv/plob_ctrl.sv
sv/price_level_order_book.sv
tb/sv/tb_price_level_order_book.sv
